// File: rtl/core/ictf_pkg.sv
// Package for the IMU tilt filter: widths, register indexes, CORDIC angle table.
// No dependencies.
package ictf_pkg;
   localparam int ANG_W = 20;
   localparam int WGT_W = 17;
   localparam int OFS_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TAB_LEN = 24;
   localparam int CW = 50;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_W = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROLL_W = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_OFS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_X_OFS = 2'd3;
   localparam logic [22:0] RAD_PER_DEG_US = 23'd4912665;

   typedef struct packed {
      logic load;
      logic sqrt_step;
      logic cordic_init;
      logic cordic_step;
      logic sel_roll;
      logic gyro_mul;
      logic gyro_mul2;
      logic blend_mul;
      logic commit;
   } cmd_type;

   function automatic logic [16:0] atan_tab(input logic [4:0] i);
      logic [16:0] t;
      begin
         case (i)
            5'd0: t = 17'd51472;
            5'd1: t = 17'd30386;
            5'd2: t = 17'd16055;
            5'd3: t = 17'd8150;
            5'd4: t = 17'd4091;
            5'd5: t = 17'd2047;
            5'd6: t = 17'd1024;
            5'd7: t = 17'd512;
            5'd8: t = 17'd256;
            5'd9: t = 17'd128;
            5'd10: t = 17'd64;
            5'd11: t = 17'd32;
            5'd12: t = 17'd16;
            5'd13: t = 17'd8;
            5'd14: t = 17'd4;
            5'd15: t = 17'd2;
            5'd16: t = 17'd1;
            default: t = 17'd0;
         endcase
         atan_tab = t;
      end
   endfunction

   function automatic logic signed [ANG_W-1:0] sat20(input logic signed [47:0] v);
      begin
         if (v > 48'sd524287) sat20 = 20'sh7FFFF;
         else if (v < -48'sd524288) sat20 = 20'sh80000;
         else sat20 = v[ANG_W-1:0];
      end
   endfunction
endpackage

// File: rtl/core/ictf_ctrl.sv
// Controller of the IMU tilt filter: sequences square root, CORDIC, gyro and blend.
// Depends on ictf_pkg.
module ictf_ctrl #(
   parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   output logic out_valid,
   input  logic out_ready,
   output ictf_pkg::cmd_type cmd
);
   import ictf_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_SQRT = 4'd1, S_CINIT = 4'd2, S_CORD = 4'd3,
      S_GMUL = 4'd4, S_GMUL2 = 4'd5, S_BLEND = 4'd6, S_COMMIT = 4'd7, S_OUT = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       roll_ff, roll_in;

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      roll_in = roll_ff;
      cmd = '0;
      cmd.sel_roll = roll_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_SQRT;
               cnt_in = '0;
               roll_in = 1'b0;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd30) state_in = S_CINIT;
         end
         S_CINIT: begin
            cmd.cordic_init = 1'b1;
            cnt_in = '0;
            state_in = S_CORD;
         end
         S_CORD: begin
            cmd.cordic_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(CORDIC_STEPS - 1)) begin
               cnt_in = '0;
               if (roll_ff) state_in = S_GMUL;
               else begin
                  roll_in = 1'b1;
                  state_in = S_SQRT;
               end
            end
         end
         S_GMUL: begin
            cmd.gyro_mul = 1'b1;
            state_in = S_GMUL2;
         end
         S_GMUL2: begin
            cmd.gyro_mul2 = 1'b1;
            state_in = S_BLEND;
         end
         S_BLEND: begin
            cmd.blend_mul = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         roll_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         roll_ff <= roll_in;
      end
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid)) else $error("accept and deliver overlap");
   a_commit_out: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> out_valid) else $error("commit not followed by result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

// File: rtl/core/ictf_dp.sv
// Datapath of the IMU tilt filter: shared root and CORDIC unit, gyro and blend math.
// Depends on ictf_pkg.
module ictf_dp #(
   parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  ictf_pkg::cmd_type cmd,
   input  logic [95:0] in_data,
   input  logic [16:0] pitch_w,
   input  logic [16:0] roll_w,
   input  logic signed [7:0] y_ofs,
   input  logic signed [7:0] x_ofs,
   output logic [79:0] out_data
);
   import ictf_pkg::*;

   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic signed [11:0] rx_ff, ry_ff;
   logic [19:0] el_ff;
   logic [61:0] rem_ff;
   logic [30:0] root_ff;
   logic [4:0]  it_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [19:0] z_ff, accp_ff, accr_ff;
   logic        zv_ff;
   logic signed [ANG_W-1:0] pest_ff, rest_ff, gps_ff, grs_ff;
   logic signed [33:0] rp_ff, rr_ff;
   logic signed [47:0] dp_ff, dr_ff;
   logic signed [47:0] bp_ff, br_ff;

   logic signed [15:0] num, p, q;
   logic [31:0] s;
   logic [61:0] n62;
   logic [63:0] trial;
   logic [1:0]  pair;
   logic [4:0]  ci;
   logic signed [CW-1:0] sx, sy;
   logic signed [19:0] z_nx;
   logic signed [20:0] rsum_y, rsum_x;
   logic [16:0] wp, wr;
   logic signed [23:0] ip, ir;
   logic signed [47:0] prod_p, prod_r;

   assign num = cmd.sel_roll ? ay_ff : ax_ff;
   assign p = cmd.sel_roll ? ax_ff : ay_ff;
   assign q = az_ff;
   assign s = 32'(p * p) + 32'(q * q);
   assign n62 = {s[31:0], 30'd0} >> 2;
   assign pair = n62[61 - 2*it_ff -: 2];
   assign trial = {rem_ff, pair} - {root_ff, 2'b01};
   assign ci = it_ff;
   assign sx = cx_ff >>> ci;
   assign sy = cy_ff >>> ci;
   assign z_nx = z_ff + (cy_ff[CW-1] ? -20'(atan_tab(ci)) : 20'(atan_tab(ci)));
   assign rsum_y = -(21'(ry_ff) + 21'(y_ofs));
   assign rsum_x = 21'(rx_ff) + 21'(x_ofs);
   assign wp = (pitch_w > 17'd65536) ? 17'd65536 : pitch_w;
   assign wr = (roll_w > 17'd65536) ? 17'd65536 : roll_w;
   assign ip = 24'(pest_ff) + 24'(dp_ff);
   assign ir = 24'(rest_ff) + 24'(dr_ff);
   assign prod_p = 48'(ip * $signed({1'b0, wp})) +
      48'(accp_ff * $signed({1'b0, 17'd65536 - wp})) + 48'sd32768;
   assign prod_r = 48'(ir * $signed({1'b0, wr})) +
      48'(accr_ff * $signed({1'b0, 17'd65536 - wr})) + 48'sd32768;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         {el_ff, ry_ff, rx_ff, az_ff, ay_ff, ax_ff} <= in_data[91:0];
         it_ff <= '0;
         rem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         if (!trial[63]) begin
            rem_ff <= trial[61:0];
            root_ff <= {root_ff[29:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[59:0], pair};
            root_ff <= {root_ff[29:0], 1'b0};
         end
         it_ff <= (it_ff == 5'd30) ? 5'd0 : it_ff + 5'd1;
      end
      if (cmd.cordic_init) begin
         cx_ff <= CW'(root_ff);
         cy_ff <= CW'(num) <<< 14;
         z_ff <= '0;
         zv_ff <= (root_ff == '0) && (num == '0);
         it_ff <= '0;
         rem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.cordic_step) begin
         if (!cy_ff[CW-1]) begin
            cx_ff <= cx_ff + sy;
            cy_ff <= cy_ff - sx;
         end else begin
            cx_ff <= cx_ff - sy;
            cy_ff <= cy_ff + sx;
         end
         z_ff <= z_nx;
         if (it_ff == 5'(CORDIC_STEPS - 1)) begin
            it_ff <= '0;
            if (cmd.sel_roll) accr_ff <= zv_ff ? '0 : z_nx;
            else accp_ff <= zv_ff ? '0 : z_nx;
         end else begin
            it_ff <= it_ff + 5'd1;
         end
      end
      if (cmd.gyro_mul) begin
         rp_ff <= 34'(rsum_y * $signed({1'b0, el_ff}));
         rr_ff <= 34'(rsum_x * $signed({1'b0, el_ff}));
      end
      if (cmd.gyro_mul2) begin
         dp_ff <= 48'((58'(rp_ff) * $signed({1'b0, RAD_PER_DEG_US}) + 58'sd2147483648) >>> 32);
         dr_ff <= 48'((58'(rr_ff) * $signed({1'b0, RAD_PER_DEG_US}) + 58'sd2147483648) >>> 32);
      end
      if (cmd.blend_mul) begin
         bp_ff <= prod_p >>> 16;
         br_ff <= prod_r >>> 16;
      end
      if (cmd.commit) begin
         pest_ff <= sat20(bp_ff);
         rest_ff <= sat20(br_ff);
         gps_ff <= sat20(48'(gps_ff) + dp_ff);
         grs_ff <= sat20(48'(grs_ff) + dr_ff);
      end
      if (reset) begin
         pest_ff <= '0;
         rest_ff <= '0;
         gps_ff <= '0;
         grs_ff <= '0;
      end
   end

   assign out_data = {grs_ff, gps_ff, rest_ff, pest_ff};
endmodule

// File: rtl/core/imu_complementary_tilt_filter.sv
// Top level of the IMU complementary tilt filter.
// Depends on ictf_pkg, ictf_ctrl and ictf_dp.
//
//  channel | direction | beat contents
//  req_    | in        | accel_x, accel_y, accel_z, rate_x, rate_y, elapsed_us
//  rsp_    | out       | pitch_angle, roll_angle, gyro_only_pitch, gyro_only_roll
//  csr_    | in        | write enable, register index, data
//
// For each sample the bit-serial root and the CORDIC loop run twice, for pitch then roll,
// on one shared unit; the gyro multiply, gyro scaling, blend and commit steps follow, and
// then rsp_tvalid is raised for the output beat.
// Reset is synchronous and clears the angle state and registers to their defaults.
// A stalled result holds rsp_tvalid; no new sample is taken until it leaves.
module imu_complementary_tilt_filter #(
   parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // accel_x, accel_y, accel_z, rate_x, rate_y, elapsed_us
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // pitch_angle, roll_angle, gyro_only_pitch, gyro_only_roll
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   import ictf_pkg::*;

   cmd_type cmd;
   logic [16:0] pitch_w_ff, roll_w_ff;
   logic signed [7:0] y_ofs_ff, x_ofs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_w_ff <= 17'd65470;
         roll_w_ff <= 17'd65208;
         y_ofs_ff <= 8'sd2;
         x_ofs_ff <= 8'sd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_PITCH_W: pitch_w_ff <= csr_wdata;
            REG_ROLL_W: roll_w_ff <= csr_wdata;
            REG_Y_OFS: y_ofs_ff <= csr_wdata[7:0];
            REG_X_OFS: x_ofs_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   ictf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .cmd(cmd)
   );

   ictf_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .in_data(req_tdata),
      .pitch_w(pitch_w_ff), .roll_w(roll_w_ff), .y_ofs(y_ofs_ff), .x_ofs(x_ofs_ff),
      .out_data(rsp_tdata)
   );
endmodule
